[sv/sliding_window_percentile_core_macros.svh]
// Assertion helpers used by the checker file.
`ifndef SLIDING_WINDOW_PERCENTILE_CORE_MACROS_SVH
`define SLIDING_WINDOW_PERCENTILE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWP_ASSERT_SAME(lbl, clk, rstn, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (con)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWP_ASSERT_NEXT(lbl, clk, rstn, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (con)) \
    else $error(msg);

`endif

[sv/swp_pkg.sv]
package swp_pkg;

  localparam int unsigned CAP_DEFAULT = 64;

  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned PERM_W      = 10;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned S_TDATA_W   = 48;
  localparam int unsigned M_TDATA_W   = 40;

  localparam logic [PERM_W-1:0] PERM_MAX = 10'd1000;

  // floor(x / 1000) == (x * RECIP) >> RECIP_SHIFT for every x below 2**20.
  localparam int unsigned       RECIP_SHIFT = 30;
  localparam int unsigned       RECIP_W     = 21;
  localparam logic [RECIP_W-1:0] RECIP      = 21'd1073742;

  typedef enum logic [0:0] {
    ACT_PUSH  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_COLL,
    ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_LOAD,
    CELL_ROT,
    CELL_COLL
  } cell_op_e;

endpackage

[sv/swp_cell.sv]
module swp_cell #(
  parameter int unsigned CNT_W  = 7,
  parameter int unsigned RANK_W = 6,
  parameter int unsigned IDX    = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swp_pkg::cell_op_e             op_i,
  input  logic [CNT_W-1:0]              fill_count_i,
  input  logic [RANK_W-1:0]             rank_i,
  input  logic [swp_pkg::SAMPLE_W-1:0]  shift_in_i,
  output logic [swp_pkg::SAMPLE_W-1:0]  shift_out_o,
  input  logic [swp_pkg::SAMPLE_W-1:0]  tok_in_i,
  input  logic                          tok_valid_in_i,
  output logic [swp_pkg::SAMPLE_W-1:0]  tok_out_o,
  output logic                          tok_valid_out_o
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic [swp_pkg::SAMPLE_W-1:0] smp_q, smp_d;
  logic [swp_pkg::SAMPLE_W-1:0] tok_q, tok_d;
  logic                         tok_vld_q, tok_vld_d;
  logic [CNT_W-1:0]             less_q, less_d;
  logic [CNT_W-1:0]             equal_q, equal_d;

  logic             cell_vld;
  logic             tok_lt;
  logic             tok_eq;
  logic [CNT_W-1:0] rank_ext;
  logic [CNT_W:0]   upper;
  logic             hit;

  assign cell_vld = IDX_C < fill_count_i;
  assign tok_lt   = tok_vld_q && (tok_q < smp_q);
  assign tok_eq   = tok_vld_q && (tok_q == smp_q);

  // This cell holds the answer when its sample's rank range covers the target rank.
  assign rank_ext = CNT_W'(rank_i);
  assign upper    = {1'b0, less_q} + {1'b0, equal_q};
  assign hit      = cell_vld && (less_q <= rank_ext) && ({1'b0, rank_ext} < upper);

  always_comb begin
    smp_d     = smp_q;
    tok_d     = tok_q;
    tok_vld_d = tok_vld_q;
    less_d    = less_q;
    equal_d   = equal_q;
    case (op_i)
      swp_pkg::CELL_PUSH: begin
        smp_d = shift_in_i;
      end
      swp_pkg::CELL_LOAD: begin
        tok_d     = smp_q;
        tok_vld_d = cell_vld;
        less_d    = '0;
        equal_d   = '0;
      end
      swp_pkg::CELL_ROT: begin
        tok_d     = tok_in_i;
        tok_vld_d = tok_valid_in_i;
        less_d    = less_q + CNT_W'(tok_lt);
        equal_d   = equal_q + CNT_W'(tok_eq);
      end
      swp_pkg::CELL_COLL: begin
        // The token row now ripples the selected sample toward the tail.
        tok_d = hit ? smp_q : tok_in_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q   <= smp_d;
    tok_q   <= tok_d;
    less_q  <= less_d;
    equal_q <= equal_d;
  end

  assign shift_out_o     = smp_q;
  assign tok_out_o       = tok_q;
  assign tok_valid_out_o = tok_vld_q;

endmodule

[sv/sliding_window_percentile_core.sv]
// Channel   Dir  tdata (low bit up)                                   tuser
// s_axis    in   sample_value[31:0], percentile_permille[41:32], pad  action (0 push, 1 query)
// m_axis    out  selected_value[31:0], sample_count[38:32], pad       -
//
// A push is taken and its beat is offered on the next cycle.
// A query on a non-empty window loads the tokens, rotates every sample past every cell
// of the chain to count its rank, ripples the chosen sample to the tail, and registers
// the result. A query on an empty window returns a zero value and a zero count.
// Reset empties the window; the sample cells are not cleared.
// The input stalls while a query runs and while an unaccepted output beat would be
// overwritten.
module sliding_window_percentile_core #(
  parameter int unsigned CAP = swp_pkg::CAP_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // sample_value[31:0], percentile_permille[41:32], zero pad [47:42]
  input  logic [swp_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // action[0]
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // selected_value[31:0], sample_count[38:32], zero pad [39]
  output logic [swp_pkg::M_TDATA_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned CNT_W  = $clog2(CAP + 1);
  localparam int unsigned RANK_W = $clog2(CAP);
  localparam int unsigned CYC_W  = $clog2(CAP);
  localparam int unsigned X_W    = swp_pkg::PERM_W + RANK_W;
  localparam int unsigned PROD_W = X_W + swp_pkg::RECIP_W;
  localparam int unsigned PAD_W  = swp_pkg::M_TDATA_W - swp_pkg::SAMPLE_W
                                   - swp_pkg::COUNT_OUT_W;

  localparam logic [CNT_W-1:0] CAP_C      = CNT_W'(CAP);
  localparam logic [CYC_W-1:0] CYC_LAST_C = CYC_W'(CAP - 1);

  swp_pkg::state_e   state_q, state_d;
  swp_pkg::cell_op_e cell_op;
  swp_pkg::action_e  in_act;

  logic [CYC_W-1:0]              cyc_q, cyc_d;
  logic [CNT_W-1:0]              fill_q, fill_d;
  logic [swp_pkg::PERM_W-1:0]    perm_q, perm_d;
  logic [X_W-1:0]                x_q;
  logic [RANK_W-1:0]             rank_q;
  logic                          out_vld_q, out_vld_d;
  logic [swp_pkg::SAMPLE_W-1:0]  out_val_q, out_val_d;
  logic [CNT_W-1:0]              out_cnt_q, out_cnt_d;

  logic [swp_pkg::SAMPLE_W-1:0]  in_sample;
  logic [swp_pkg::PERM_W-1:0]    in_perm;
  logic                          s_acc;
  logic                          cyc_last;
  logic                          fill_empty;
  logic                          out_load;
  logic [CNT_W-1:0]              fill_inc;
  logic [CNT_W-1:0]              fill_m1;
  logic [PROD_W-1:0]             prod;

  logic [swp_pkg::SAMPLE_W-1:0]  smp_chain [CAP];
  logic [swp_pkg::SAMPLE_W-1:0]  tok_chain [CAP];
  logic                          tokv_chain [CAP];
  logic [swp_pkg::SAMPLE_W-1:0]  tok_head;
  logic                          tokv_head;

  assign in_sample  = s_axis_tdata_i[swp_pkg::SAMPLE_W-1:0];
  assign in_perm    = s_axis_tdata_i[swp_pkg::SAMPLE_W +: swp_pkg::PERM_W];
  assign in_act     = swp_pkg::action_e'(s_axis_tuser_i);
  assign s_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign cyc_last   = cyc_q == CYC_LAST_C;
  assign fill_empty = fill_q == '0;
  assign fill_inc   = (fill_q == CAP_C) ? fill_q : fill_q + 1'b1;
  assign fill_m1    = fill_q - 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swp_pkg::ST_IDLE: begin
        if (s_acc && in_act == swp_pkg::ACT_QUERY && !fill_empty) begin
          state_d = swp_pkg::ST_ROT;
        end
      end
      swp_pkg::ST_ROT: begin
        if (cyc_last) begin
          state_d = swp_pkg::ST_COLL;
        end
      end
      swp_pkg::ST_COLL: begin
        if (cyc_last) begin
          state_d = swp_pkg::ST_FIN;
        end
      end
      swp_pkg::ST_FIN: begin
        state_d = swp_pkg::ST_IDLE;
      end
      default: begin
        state_d = swp_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    cell_op         = swp_pkg::CELL_HOLD;
    out_load        = 1'b0;
    unique case (state_q)
      swp_pkg::ST_IDLE: begin
        s_axis_tready_o = !out_vld_q || m_axis_tready_i;
        if (s_acc) begin
          if (in_act == swp_pkg::ACT_PUSH) begin
            cell_op  = swp_pkg::CELL_PUSH;
            out_load = 1'b1;
          end else if (fill_empty) begin
            out_load = 1'b1;
          end else begin
            cell_op = swp_pkg::CELL_LOAD;
          end
        end
      end
      swp_pkg::ST_ROT: begin
        cell_op = swp_pkg::CELL_ROT;
      end
      swp_pkg::ST_COLL: begin
        cell_op = swp_pkg::CELL_COLL;
      end
      swp_pkg::ST_FIN: begin
        out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state_q == swp_pkg::ST_ROT || state_q == swp_pkg::ST_COLL) begin
      cyc_d = cyc_last ? '0 : cyc_q + 1'b1;
    end else begin
      cyc_d = '0;
    end
  end

  assign fill_d = (s_acc && in_act == swp_pkg::ACT_PUSH) ? fill_inc : fill_q;
  assign perm_d = s_acc ? ((in_perm > swp_pkg::PERM_MAX) ? swp_pkg::PERM_MAX : in_perm)
                        : perm_q;

  always_comb begin
    out_val_d = out_val_q;
    out_cnt_d = out_cnt_q;
    if (out_load) begin
      out_val_d = (state_q == swp_pkg::ST_FIN) ? tok_chain[CAP-1] : '0;
      out_cnt_d = fill_d;
    end
  end

  assign out_vld_d = out_load ? 1'b1 : (out_vld_q && !m_axis_tready_i);

  // The token row is a ring while counting and starts empty while collecting.
  assign tok_head  = (state_q == swp_pkg::ST_ROT) ? tok_chain[CAP-1] : '0;
  assign tokv_head = (state_q == swp_pkg::ST_ROT) ? tokv_chain[CAP-1] : 1'b0;

  // Rank pipeline: the product p*(n-1), then the division by 1000 as a reciprocal.
  // Both settle within the counting pass.
  assign prod = PROD_W'(x_q) * PROD_W'(swp_pkg::RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swp_pkg::ST_IDLE;
      cyc_q     <= '0;
      fill_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cyc_q     <= cyc_d;
      fill_q    <= fill_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    perm_q    <= perm_d;
    x_q       <= X_W'(perm_q) * X_W'(fill_m1[RANK_W-1:0]);
    rank_q    <= prod[swp_pkg::RECIP_SHIFT +: RANK_W];
    out_val_q <= out_val_d;
    out_cnt_q <= out_cnt_d;
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic [swp_pkg::SAMPLE_W-1:0] shift_in;
    logic [swp_pkg::SAMPLE_W-1:0] tok_in;
    logic                         tokv_in;

    if (i == 0) begin : g_head
      assign shift_in = in_sample;
      assign tok_in   = tok_head;
      assign tokv_in  = tokv_head;
    end else begin : g_body
      assign shift_in = smp_chain[i-1];
      assign tok_in   = tok_chain[i-1];
      assign tokv_in  = tokv_chain[i-1];
    end

    swp_cell #(
      .CNT_W  (CNT_W),
      .RANK_W (RANK_W),
      .IDX    (i)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .op_i            (cell_op),
      .fill_count_i    (fill_q),
      .rank_i          (rank_q),
      .shift_in_i      (shift_in),
      .shift_out_o     (smp_chain[i]),
      .tok_in_i        (tok_in),
      .tok_valid_in_i  (tokv_in),
      .tok_out_o       (tok_chain[i]),
      .tok_valid_out_o (tokv_chain[i])
    );
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}},
                            swp_pkg::COUNT_OUT_W'(out_cnt_q),
                            out_val_q};

endmodule

[sv/swp_checker.sv]
`include "sliding_window_percentile_core_macros.svh"

module swp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [swp_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  input logic                          s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [swp_pkg::M_TDATA_W-1:0] m_axis_tdata_o
);

  logic s_acc;
  logic m_stall;
  logic push_acc;

  assign s_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign m_stall  = m_axis_tvalid_o && !m_axis_tready_i;
  assign push_acc = s_acc && (s_axis_tuser_i == swp_pkg::ACT_PUSH) && (s_axis_tdata_i != '1);

  `SWP_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, m_stall, m_axis_tvalid_o, "output beat dropped while stalled")
  `SWP_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, m_stall, $stable(m_axis_tdata_o), "output beat changed while stalled")
  `SWP_ASSERT_NEXT(a_accept_then_busy_or_result, clk_i, rst_ni, s_acc, m_axis_tvalid_o || !s_axis_tready_o, "input taken while neither result pending nor busy")
  `SWP_ASSERT_NEXT(a_push_gives_zero, clk_i, rst_ni, push_acc, m_axis_tvalid_o && (m_axis_tdata_o[swp_pkg::SAMPLE_W-1:0] == '0), "push beat missing or nonzero value")

endmodule

bind sliding_window_percentile_core swp_checker u_swp_checker (.*);
